// File: hdl/sip_pkg.sv
// ----------------------------------------------------------------------------
// Segment intersection package
// Widths, types and stage payloads shared by the segment intersection pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package sip_pkg;

  localparam int CW = 16;
  localparam int DW = CW + 1;
  localparam int PW = 2 * DW;
  localparam int XW = PW + 1;
  localparam int QW = DW;
  localparam int NW = XW + DW;

  typedef logic signed [CW-1:0] coord_t;
  typedef logic signed [DW-1:0] diff_t;
  typedef logic signed [PW-1:0] prod_t;
  typedef logic signed [XW-1:0] xprod_t;
  typedef logic [XW-1:0] mag_t;
  typedef logic [DW-1:0] dmag_t;
  typedef logic [QW-1:0] quo_t;
  typedef logic [NW-1:0] num_t;

  typedef struct packed {
    logic   vld;
    coord_t asx;
    coord_t asy;
    diff_t  ax;
    diff_t  ay;
    xprod_t den;
    xprod_t tn;
    xprod_t un;
  } cross_t;

  typedef struct packed {
    mag_t rem;
    quo_t low;
    quo_t q;
  } div_lane_t;

  typedef struct packed {
    logic      vld;
    logic      hit;
    coord_t    asx;
    coord_t    asy;
    logic      neg_x;
    logic      neg_y;
    mag_t      dm;
    div_lane_t lx;
    div_lane_t ly;
  } div_stage_t;

endpackage

`default_nettype wire

// File: hdl/segment_intersection_point.sv
// ----------------------------------------------------------------------------
// Segment intersection point
// Tests two segments for a strict crossing and returns the crossing point.
// ----------------------------------------------------------------------------
// Each input request carries the endpoints of segments A and B as signed Q12.4
// coordinates. Each result request carries the hit flag and the crossing point,
// which reads zero when the segments do not cross strictly inside both.
// The block is a single pipeline: three stages form the cross products, two
// stages decide the hit and form the dividends, one stage per quotient bit
// (17 stages) performs the division, and one output register follows.
// A new request is accepted in every cycle in which in_stall is low.
// When the receiver stalls while a result is held, the whole pipeline freezes
// and in_stall rises; nothing is lost or repeated. Empty stages do not collapse.
// Reset clears every valid bit; the pipeline then accepts input at once.
// ----------------------------------------------------------------------------
`default_nettype none

module segment_intersection_point (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire sip_pkg::coord_t        in_a_start_x,
  input  wire sip_pkg::coord_t        in_a_start_y,
  input  wire sip_pkg::coord_t        in_a_end_x,
  input  wire sip_pkg::coord_t        in_a_end_y,
  input  wire sip_pkg::coord_t        in_b_start_x,
  input  wire sip_pkg::coord_t        in_b_start_y,
  input  wire sip_pkg::coord_t        in_b_end_x,
  input  wire sip_pkg::coord_t        in_b_end_y,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic                        out_hit,
  output sip_pkg::coord_t             out_cross_x,
  output sip_pkg::coord_t             out_cross_y
);

  logic                en;
  sip_pkg::cross_t     cross_st;
  sip_pkg::div_stage_t chain [sip_pkg::QW+1];
  sip_pkg::div_stage_t last;
  logic                out_valid_r, out_hit_r;
  sip_pkg::coord_t     out_x_r, out_y_r, x_nxt, y_nxt;

  assign en       = !(out_valid_r && out_stall);
  assign in_stall = !en;

  sip_cross u_cross (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .in_vld (in_valid),
    .asx    (in_a_start_x),
    .asy    (in_a_start_y),
    .aex    (in_a_end_x),
    .aey    (in_a_end_y),
    .bsx    (in_b_start_x),
    .bsy    (in_b_start_y),
    .bex    (in_b_end_x),
    .bey    (in_b_end_y),
    .out    (cross_st)
  );

  sip_scale u_scale (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .in    (cross_st),
    .out   (chain[0])
  );

  for (genvar i = 0; i < sip_pkg::QW; i++) begin : g_div
    sip_div_step u_step (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .in    (chain[i]),
      .out   (chain[i+1])
    );
  end

  assign last = chain[sip_pkg::QW];

  always_comb begin
    x_nxt = last.asx + (last.neg_x ? sip_pkg::coord_t'(-last.lx.q)
                                   : sip_pkg::coord_t'(last.lx.q));
    y_nxt = last.asy + (last.neg_y ? sip_pkg::coord_t'(-last.ly.q)
                                   : sip_pkg::coord_t'(last.ly.q));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= last.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_hit_r <= last.hit;
      out_x_r   <= last.hit ? x_nxt : '0;
      out_y_r   <= last.hit ? y_nxt : '0;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_hit     = out_hit_r;
  assign out_cross_x = out_x_r;
  assign out_cross_y = out_y_r;

endmodule

`default_nettype wire

// File: hdl/sip_cross.sv
// ----------------------------------------------------------------------------
// Segment intersection cross products
// Forms direction vectors, the six products and the three cross products.
// ----------------------------------------------------------------------------
`default_nettype none

module sip_cross (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            en,
  input  wire logic            in_vld,
  input  wire sip_pkg::coord_t asx,
  input  wire sip_pkg::coord_t asy,
  input  wire sip_pkg::coord_t aex,
  input  wire sip_pkg::coord_t aey,
  input  wire sip_pkg::coord_t bsx,
  input  wire sip_pkg::coord_t bsy,
  input  wire sip_pkg::coord_t bex,
  input  wire sip_pkg::coord_t bey,
  output sip_pkg::cross_t      out
);

  logic           v1_r, v2_r, v3_r;
  sip_pkg::coord_t asx1_r, asy1_r, asx2_r, asy2_r, asx3_r, asy3_r;
  sip_pkg::diff_t ax_r, ay_r, bx_r, by_r, cx_r, cy_r;
  sip_pkg::diff_t ax2_r, ay2_r, ax3_r, ay3_r;
  sip_pkg::prod_t p_axby_r, p_aybx_r, p_cxby_r, p_cybx_r, p_cxay_r, p_cyax_r;
  sip_pkg::xprod_t den_r, tn_r, un_r;

  function automatic sip_pkg::diff_t sub(sip_pkg::coord_t a, sip_pkg::coord_t b);
    sub = sip_pkg::diff_t'($signed({a[sip_pkg::CW-1], a}) - $signed({b[sip_pkg::CW-1], b}));
  endfunction

  function automatic sip_pkg::xprod_t xsub(sip_pkg::prod_t a, sip_pkg::prod_t b);
    xsub = sip_pkg::xprod_t'($signed({a[sip_pkg::PW-1], a}) - $signed({b[sip_pkg::PW-1], b}));
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_vld;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      asx1_r   <= asx;
      asy1_r   <= asy;
      ax_r     <= sub(aex, asx);
      ay_r     <= sub(aey, asy);
      bx_r     <= sub(bex, bsx);
      by_r     <= sub(bey, bsy);
      cx_r     <= sub(bsx, asx);
      cy_r     <= sub(bsy, asy);
      asx2_r   <= asx1_r;
      asy2_r   <= asy1_r;
      ax2_r    <= ax_r;
      ay2_r    <= ay_r;
      p_axby_r <= ax_r * by_r;
      p_aybx_r <= ay_r * bx_r;
      p_cxby_r <= cx_r * by_r;
      p_cybx_r <= cy_r * bx_r;
      p_cxay_r <= cx_r * ay_r;
      p_cyax_r <= cy_r * ax_r;
      asx3_r   <= asx2_r;
      asy3_r   <= asy2_r;
      ax3_r    <= ax2_r;
      ay3_r    <= ay2_r;
      den_r    <= xsub(p_axby_r, p_aybx_r);
      tn_r     <= xsub(p_cxby_r, p_cybx_r);
      un_r     <= xsub(p_cxay_r, p_cyax_r);
    end
  end

  always_comb begin
    out.vld = v3_r;
    out.asx = asx3_r;
    out.asy = asy3_r;
    out.ax  = ax3_r;
    out.ay  = ay3_r;
    out.den = den_r;
    out.tn  = tn_r;
    out.un  = un_r;
  end

endmodule

`default_nettype wire

// File: hdl/sip_scale.sv
// ----------------------------------------------------------------------------
// Segment intersection hit test and scaling
// Decides the hit by sign and magnitude and forms the two dividends.
// ----------------------------------------------------------------------------
`default_nettype none

module sip_scale (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             en,
  input  wire sip_pkg::cross_t  in,
  output sip_pkg::div_stage_t   out
);

  logic            v_r, hit_r, neg_x_r, neg_y_r;
  sip_pkg::coord_t asx_r, asy_r;
  sip_pkg::mag_t   nm_r, dm_r;
  sip_pkg::dmag_t  mx_r, my_r;
  logic            hit_nxt;
  sip_pkg::num_t   nx, ny;
  sip_pkg::div_stage_t st_r;

  function automatic logic inside_unit(sip_pkg::xprod_t num, sip_pkg::xprod_t den);
    if (!den[sip_pkg::XW-1]) begin
      inside_unit = (num > 0) && (num < den);
    end else begin
      inside_unit = (num < 0) && (num > den);
    end
  endfunction

  function automatic sip_pkg::mag_t xmag(sip_pkg::xprod_t v);
    xmag = v[sip_pkg::XW-1] ? sip_pkg::mag_t'(-v) : sip_pkg::mag_t'(v);
  endfunction

  function automatic sip_pkg::dmag_t dmag(sip_pkg::diff_t v);
    dmag = v[sip_pkg::DW-1] ? sip_pkg::dmag_t'(-v) : sip_pkg::dmag_t'(v);
  endfunction

  always_comb begin
    hit_nxt = (in.den != '0) && inside_unit(in.tn, in.den) && inside_unit(in.un, in.den);
    nx = sip_pkg::num_t'(nm_r) * sip_pkg::num_t'(mx_r);
    ny = sip_pkg::num_t'(nm_r) * sip_pkg::num_t'(my_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r      <= 1'b0;
      st_r.vld <= 1'b0;
    end else if (en) begin
      v_r      <= in.vld;
      st_r.vld <= v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hit_r      <= hit_nxt;
      asx_r      <= in.asx;
      asy_r      <= in.asy;
      neg_x_r    <= in.ax[sip_pkg::DW-1];
      neg_y_r    <= in.ay[sip_pkg::DW-1];
      nm_r       <= xmag(in.tn);
      dm_r       <= xmag(in.den);
      mx_r       <= dmag(in.ax);
      my_r       <= dmag(in.ay);
      st_r.hit   <= hit_r;
      st_r.asx   <= asx_r;
      st_r.asy   <= asy_r;
      st_r.neg_x <= neg_x_r;
      st_r.neg_y <= neg_y_r;
      st_r.dm    <= dm_r;
      st_r.lx    <= '{rem: nx[sip_pkg::NW-1:sip_pkg::QW], low: nx[sip_pkg::QW-1:0], q: '0};
      st_r.ly    <= '{rem: ny[sip_pkg::NW-1:sip_pkg::QW], low: ny[sip_pkg::QW-1:0], q: '0};
    end
  end

  assign out = st_r;

endmodule

`default_nettype wire

// File: hdl/sip_div_step.sv
// ----------------------------------------------------------------------------
// Segment intersection division step
// One restoring-division stage that yields one quotient bit for each lane.
// ----------------------------------------------------------------------------
`default_nettype none

module sip_div_step (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                en,
  input  wire sip_pkg::div_stage_t in,
  output sip_pkg::div_stage_t      out
);

  sip_pkg::div_stage_t st_r;
  sip_pkg::div_stage_t st_nxt;

  function automatic sip_pkg::div_lane_t step(sip_pkg::div_lane_t l, sip_pkg::mag_t dm);
    logic [sip_pkg::XW:0] sh;
    logic                 ge;
    sh = {l.rem, l.low[sip_pkg::QW-1]};
    ge = sh >= {1'b0, dm};
    step.rem = ge ? sip_pkg::mag_t'(sh - {1'b0, dm}) : sip_pkg::mag_t'(sh);
    step.low = {l.low[sip_pkg::QW-2:0], 1'b0};
    step.q   = {l.q[sip_pkg::QW-2:0], ge};
  endfunction

  always_comb begin
    st_nxt    = in;
    st_nxt.lx = step(in.lx, in.dm);
    st_nxt.ly = step(in.ly, in.dm);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.vld <= 1'b0;
    end else if (en) begin
      st_r.vld <= st_nxt.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r.hit   <= st_nxt.hit;
      st_r.asx   <= st_nxt.asx;
      st_r.asy   <= st_nxt.asy;
      st_r.neg_x <= st_nxt.neg_x;
      st_r.neg_y <= st_nxt.neg_y;
      st_r.dm    <= st_nxt.dm;
      st_r.lx    <= st_nxt.lx;
      st_r.ly    <= st_nxt.ly;
    end
  end

  assign out = st_r;

endmodule

`default_nettype wire

// File: sim/tb_segment_intersection_point.sv
// ----------------------------------------------------------------------------
// Segment intersection point testbench
// Drives segment pairs through the pipeline with random bursts and stalls, and
// checks every hit flag and crossing point against fixed expectations or an exact predictor.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_segment_intersection_point;

  typedef struct packed {
    logic signed [15:0] asx, asy, aex, aey, bsx, bsy, bex, bey;
  } seg_pair_t;

  typedef struct packed {
    logic               hit;
    logic signed [15:0] px, py;
  } crossing_t;

  typedef struct {
    seg_pair_t p;
    logic      known;
    crossing_t r;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  seg_pair_t drv = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_hit;
  logic signed [15:0] out_cross_x, out_cross_y;

  crossing_t crossings_due[$];
  int errors = 0;
  bit hold_long = 1'b0;
  bit stim_done = 1'b0;

  always #10 clk = ~clk;

  segment_intersection_point u_top (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_a_start_x(drv.asx), .in_a_start_y(drv.asy),
    .in_a_end_x(drv.aex), .in_a_end_y(drv.aey),
    .in_b_start_x(drv.bsx), .in_b_start_y(drv.bsy),
    .in_b_end_x(drv.bex), .in_b_end_y(drv.bey),
    .out_valid(out_valid), .out_stall(out_stall), .out_hit(out_hit),
    .out_cross_x(out_cross_x), .out_cross_y(out_cross_y)
  );

  function automatic logic signed [15:0] scale_dir(logic signed [35:0] num,
      logic signed [35:0] den, logic signed [16:0] dir);
    logic [35:0] nm, dm;
    logic [16:0] m;
    logic [52:0] q;
    nm = num[35] ? -num : num;
    dm = den[35] ? -den : den;
    m = dir[16] ? -dir : dir;
    q = (53'(nm) * 53'(m)) / 53'(dm);
    return dir[16] ? -q[15:0] : q[15:0];
  endfunction

  function automatic crossing_t predict_crossing(seg_pair_t s);
    logic signed [16:0] ax, ay, bx, by, cx, cy;
    logic signed [35:0] den, tn, un;
    crossing_t r;
    bit ok;
    r = '0;
    ax = 17'(s.aex) - 17'(s.asx);
    ay = 17'(s.aey) - 17'(s.asy);
    bx = 17'(s.bex) - 17'(s.bsx);
    by = 17'(s.bey) - 17'(s.bsy);
    cx = 17'(s.bsx) - 17'(s.asx);
    cy = 17'(s.bsy) - 17'(s.asy);
    den = 36'(ax) * 36'(by) - 36'(ay) * 36'(bx);
    tn = 36'(cx) * 36'(by) - 36'(cy) * 36'(bx);
    un = 36'(cx) * 36'(ay) - 36'(cy) * 36'(ax);
    if (den == 0) return r;
    if (den > 0) ok = tn > 0 && tn < den && un > 0 && un < den;
    else ok = tn < 0 && tn > den && un < 0 && un > den;
    if (!ok) return r;
    r.hit = 1'b1;
    r.px = s.asx + scale_dir(tn, den, ax);
    r.py = s.asy + scale_dir(tn, den, ay);
    return r;
  endfunction

  function automatic seg_pair_t rand_pair();
    seg_pair_t s;
    logic signed [15:0] cx, cy;
    int sp;
    s = {$urandom, $urandom, $urandom, $urandom};
    case ($urandom_range(0, 3))
      0: ;
      1: begin
        cx = 16'($urandom); cy = 16'($urandom); sp = 1 << $urandom_range(2, 14);
        s.asx = cx - 16'($urandom_range(1, sp)); s.aex = cx + 16'($urandom_range(1, sp));
        s.asy = cy - 16'($urandom_range(0, sp)); s.aey = cy + 16'($urandom_range(0, sp));
        s.bsx = cx + 16'($urandom_range(0, sp)); s.bex = cx - 16'($urandom_range(0, sp));
        s.bsy = cy - 16'($urandom_range(1, sp)); s.bey = cy + 16'($urandom_range(1, sp));
      end
      2: begin
        sp = $urandom_range(1, 8);
        s.bsx = s.asx + 16'(sp); s.bex = s.aex + 16'(sp);
        s.bsy = s.asy; s.bey = s.aey;
      end
      default: begin
        s.asx = 16'($urandom_range(0, 64)) - 16'sd32; s.asy = 16'($urandom_range(0, 64)) - 16'sd32;
        s.aex = 16'($urandom_range(0, 64)) - 16'sd32; s.aey = 16'($urandom_range(0, 64)) - 16'sd32;
        s.bsx = 16'($urandom_range(0, 64)) - 16'sd32; s.bsy = 16'($urandom_range(0, 64)) - 16'sd32;
        s.bex = 16'($urandom_range(0, 64)) - 16'sd32; s.bey = 16'($urandom_range(0, 64)) - 16'sd32;
      end
    endcase
    return s;
  endfunction

  task automatic offer_pair(seg_pair_t s, crossing_t r);
    drv <= s;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    crossings_due.push_back(r);
    @(negedge clk);
  endtask

  task automatic pause_sender();
    in_valid <= 1'b0;
    repeat ($urandom_range(1, 6)) @(negedge clk);
  endtask

  stim_row_t rows[$];

  initial begin
    stim_row_t row;
    int burst;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    // Extremes, parallel, collinear, degenerate, endpoint touch, and crossings.
    rows.push_back('{'{16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff,
                       16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000}, 1'b0, '0});
    rows.push_back('{'{16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff,
                       16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff}, 1'b0, '0});
    rows.push_back('{'{0, 0, 16, 0, 0, 16, 16, 16}, 1'b1, '0});
    rows.push_back('{'{0, 0, 16, 16, 32, 32, 48, 48}, 1'b1, '0});
    rows.push_back('{'{0, 0, 32, 32, 16, 16, 48, 48}, 1'b1, '0});
    rows.push_back('{'{5, 5, 5, 5, 0, 0, 16, 16}, 1'b1, '0});
    rows.push_back('{'{0, 0, 16, 0, 16, -16, 16, 16}, 1'b1, '0});
    rows.push_back('{'{0, 0, 16, 0, 0, -16, 0, 16}, 1'b1, '0});
    rows.push_back('{'{0, 0, 16, 0, 8, 0, 8, 16}, 1'b1, '0});
    rows.push_back('{'{0, 0, 32, 0, 16, -16, 16, 16}, 1'b1, '{1'b1, 16, 0}});
    rows.push_back('{'{-32, -32, 32, 32, -32, 32, 32, -32}, 1'b1, '{1'b1, 0, 0}});
    rows.push_back('{'{0, 0, 0, 0, 0, 0, 0, 0}, 1'b1, '0});
    rows.push_back('{'{0, 0, 3, 7, 2, -5, 1, 9}, 1'b0, '0});
    rows.push_back('{'{16'sh7fff, 0, 16'sh8000, 0, 0, 16'sh7fff, 0, 16'sh8000}, 1'b0, '0});
    rows.push_back('{'{16'shffff, 16'shffff, 16'sh8000, 16'sh8000,
                       16'sh8001, 16'shffff, 16'shffff, 16'sh8001}, 1'b0, '0});
    foreach (rows[i]) begin
      row = rows[i];
      offer_pair(row.p, row.known ? row.r : predict_crossing(row.p));
    end
    pause_sender();
    for (int n = 0; n < 1050; ) begin
      burst = $urandom_range(1, 40);
      for (int k = 0; k < burst && n < 1050; k++, n++) begin
        row.p = rand_pair();
        offer_pair(row.p, predict_crossing(row.p));
        if (n == 300) hold_long = 1'b1;
        if (n == 600) begin
          in_valid <= 1'b0;
          while (crossings_due.size() != 0) @(negedge clk);
        end
      end
      if ($urandom_range(0, 2) == 0) pause_sender();
    end
    in_valid <= 1'b0;
    stim_done = 1'b1;
  end

  initial begin
    int patt;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_long) begin
        out_stall <= 1'b1;
        repeat (200) @(negedge clk);
        hold_long = 1'b0;
      end
      patt = $urandom_range(0, 7);
      if (patt < 3) out_stall <= 1'b0;
      else if (patt < 6) out_stall <= $urandom_range(0, 1);
      else out_stall <= 1'b1;
    end
  end

  always @(posedge clk) begin
    crossing_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (crossings_due.size() == 0) begin
        $error("result with no pending request");
        errors++;
      end else begin
        e = crossings_due.pop_front();
        if (out_hit !== e.hit) begin
          $error("hit: expected %0d actual %0d", e.hit, out_hit); errors++;
        end
        if (out_cross_x !== e.px) begin
          $error("cross_x: expected %0d actual %0d", e.px, out_cross_x); errors++;
        end
        if (out_cross_y !== e.py) begin
          $error("cross_y: expected %0d actual %0d", e.py, out_cross_y); errors++;
        end
      end
    end
  end

  initial begin
    wait (stim_done);
    while (crossings_due.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (errors == 0 && crossings_due.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Some tests failed");
    $finish;
  end

endmodule

`default_nettype wire
